// ===== rtl/gehb_pkg.sv =====
// Shared types, constants and register codes for the GENEVE encapsulation header builder.
package gehb_pkg;

    localparam int NUM_WORDS = 8;

    localparam logic [2:0]  LAST_WORD      = 3'd7;
    localparam logic [3:0]  BYTES_FULL     = 4'd8;
    localparam logic [3:0]  BYTES_LAST     = 4'd6;

    localparam logic [7:0]  IPV4_VER_IHL   = 8'h45;
    localparam logic [7:0]  IPV4_TTL       = 8'hFF;
    localparam logic [7:0]  IPV4_PROTO_UDP = 8'd17;
    localparam logic [15:0] OUTER_OVERHEAD = 16'd62;
    localparam logic [15:0] UDP_OVERHEAD   = 16'd42;
    localparam logic [31:0] GENEVE_BASE    = 32'h0300_6558;
    localparam logic [31:0] GENEVE_OPT     = 32'hDEAD_BE02;
    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;

    // Constant 16-bit words of the IPv4 header that enter the checksum
    localparam logic [17:0] CSUM_CONST     = 18'h0_4500 + 18'h0_FF11;

    typedef enum logic [2:0] {
        CFG_SRC_IP_PAIR = 3'd0,
        CFG_DST_IP_PAIR = 3'd1,
        CFG_PORT_QUAD   = 3'd2,
        CFG_SRC_MAC_FWD = 3'd3,
        CFG_SRC_MAC_REV = 3'd4,
        CFG_DST_MAC_FWD = 3'd5,
        CFG_DST_MAC_REV = 3'd6,
        CFG_TENANT_CTL  = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic        direction;
        logic [63:0] flow_sid;
        logic [15:0] payload_len;
        logic [47:0] orig_dst_mac;
        logic [47:0] orig_src_mac;
        logic [15:0] orig_ethertype;
    } t_in_item;

    typedef struct packed {
        logic [63:0] hdr_word;
        logic [2:0]  word_index;
        logic [3:0]  valid_bytes;
        logic        drop;
        logic        last;
    } t_out_item;

    typedef struct packed {
        logic [63:0] src_ip_pair;
        logic [63:0] dst_ip_pair;
        logic [63:0] port_quad;
        logic [47:0] src_mac_fwd;
        logic [47:0] src_mac_rev;
        logic [47:0] dst_mac_fwd;
        logic [47:0] dst_mac_rev;
        logic [25:0] tenant_ctl;
    } t_cfg;

    // Per-item header fields after direction and mode selection
    typedef struct packed {
        logic        drop;
        logic        direction;
        logic [63:0] flow_sid;
        logic [31:0] src_ip;
        logic [31:0] dst_ip;
        logic [15:0] udp_sport;
        logic [15:0] udp_dport;
        logic [15:0] ip_len;
        logic [15:0] udp_len;
        logic [23:0] vni;
        logic [47:0] eth_dst;
        logic [47:0] eth_src;
        logic [15:0] eth_type;
    } t_hdr_fields;

    // Finished header handed to the word serializer
    typedef struct packed {
        logic                       drop;
        logic [NUM_WORDS-1:0][63:0] words;
    } t_hdr_set;

endpackage

// ===== rtl/gehb_hdr_pipe.sv =====
// Three-stage pipeline: field selection, checksum partial sums, checksum fold and word assembly.
module gehb_hdr_pipe (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  gehb_pkg::t_cfg      i_cfg,
    input  logic                i_valid,
    output logic                o_stall,
    input  gehb_pkg::t_in_item  i_data,
    output logic                o_valid,
    input  logic                i_take,
    output gehb_pkg::t_hdr_set  o_hdr
);

    logic                  r_v1, r_v2, r_v3;
    gehb_pkg::t_hdr_fields r_f1, r_f2, r_f3;
    logic [17:0]           r_sum_a, r_sum_b;
    logic [15:0]           r_csum;

    logic                  en1, en2, en3;
    gehb_pkg::t_hdr_fields n_f1;
    logic [17:0]           n_sum_a, n_sum_b;
    logic [18:0]           sum_all;
    logic [16:0]           fold1;
    logic [15:0]           fold2;
    logic [15:0]           n_csum;
    logic                  dir;
    logic                  static_mac;

    // Each stage loads when it is empty or its content moves on
    assign en3     = !r_v3 || i_take;
    assign en2     = !r_v2 || en3;
    assign en1     = !r_v1 || en2;
    assign o_stall = !en1;
    assign o_valid = r_v3;

    // Stage 1: pick direction-dependent fields, the Ethernet addresses and type, and the lengths
    assign dir        = i_data.direction;
    assign static_mac = i_cfg.tenant_ctl[25];

    always_comb begin
        n_f1.drop       = !i_cfg.tenant_ctl[24];
        n_f1.direction  = dir;
        n_f1.flow_sid   = i_data.flow_sid;
        n_f1.src_ip     = dir ? i_cfg.src_ip_pair[31:0]  : i_cfg.src_ip_pair[63:32];
        n_f1.dst_ip     = dir ? i_cfg.dst_ip_pair[31:0]  : i_cfg.dst_ip_pair[63:32];
        n_f1.udp_sport  = dir ? i_cfg.port_quad[47:32]   : i_cfg.port_quad[63:48];
        n_f1.udp_dport  = dir ? i_cfg.port_quad[15:0]    : i_cfg.port_quad[31:16];
        n_f1.ip_len     = gehb_pkg::OUTER_OVERHEAD + i_data.payload_len;
        n_f1.udp_len    = gehb_pkg::UDP_OVERHEAD + i_data.payload_len;
        n_f1.vni        = i_cfg.tenant_ctl[23:0];
        if (static_mac) begin
            n_f1.eth_dst  = dir ? i_cfg.dst_mac_rev : i_cfg.dst_mac_fwd;
            n_f1.eth_src  = dir ? i_cfg.src_mac_rev : i_cfg.src_mac_fwd;
            n_f1.eth_type = gehb_pkg::ETHERTYPE_IPV4;
        end else begin
            n_f1.eth_dst  = i_data.orig_dst_mac;
            n_f1.eth_src  = i_data.orig_src_mac;
            n_f1.eth_type = i_data.orig_ethertype;
        end
    end

    // Stage 2: two partial one's-complement sums over the IPv4 header words
    assign n_sum_a = gehb_pkg::CSUM_CONST + {2'b00, r_f1.ip_len} + {2'b00, r_f1.src_ip[31:16]};
    assign n_sum_b = {2'b00, r_f1.src_ip[15:0]} + {2'b00, r_f1.dst_ip[31:16]}
                   + {2'b00, r_f1.dst_ip[15:0]};

    // Stage 3: add, fold end-around carries twice, invert
    assign sum_all = {1'b0, r_sum_a} + {1'b0, r_sum_b};
    assign fold1   = {1'b0, sum_all[15:0]} + {14'b0, sum_all[18:16]};
    assign fold2   = fold1[15:0] + {15'b0, fold1[16]};
    assign n_csum  = ~fold2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (en1) begin
                r_v1 <= i_valid;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
            if (en3) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_f1 <= n_f1;
        end
        if (en2) begin
            r_f2    <= r_f1;
            r_sum_a <= n_sum_a;
            r_sum_b <= n_sum_b;
        end
        if (en3) begin
            r_f3   <= r_f2;
            r_csum <= n_csum;
        end
    end

    // Lay the fields out as eight big-endian words
    always_comb begin
        o_hdr.drop     = r_f3.drop;
        o_hdr.words[0] = {gehb_pkg::IPV4_VER_IHL, 8'h00, r_f3.ip_len, 16'h0000, 16'h0000};
        o_hdr.words[1] = {gehb_pkg::IPV4_TTL, gehb_pkg::IPV4_PROTO_UDP, r_csum, r_f3.src_ip};
        o_hdr.words[2] = {r_f3.dst_ip, r_f3.udp_sport, r_f3.udp_dport};
        o_hdr.words[3] = {r_f3.udp_len, 16'h0000, gehb_pkg::GENEVE_BASE};
        o_hdr.words[4] = {r_f3.vni, 8'h00, gehb_pkg::GENEVE_OPT};
        o_hdr.words[5] = {r_f3.flow_sid[63:1], r_f3.flow_sid[0] | r_f3.direction};
        o_hdr.words[6] = {r_f3.eth_dst, r_f3.eth_src[47:32]};
        o_hdr.words[7] = {r_f3.eth_src[31:0], r_f3.eth_type, 16'h0000};
    end

endmodule

// ===== rtl/geneve_encap_header_builder.sv =====
// Top level: configuration registers, header pipeline and output word serializer.
// Path: an accepted item passes the three pipeline stages, then the output register, before
//   its first word is shown.
// Output: one header word per cycle through the output register while the receiver does not
//   stall; an item gives eight words, a dropped item a single result.
// Reset: synchronous, active low; clears all valid bits and all configuration registers.
module geneve_encap_header_builder (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_idx,
    input  logic [63:0]         i_cfg_data,
    input  logic                i_valid,
    output logic                o_stall,
    input  gehb_pkg::t_in_item  i_data,
    output logic                o_valid,
    input  logic                i_stall,
    output gehb_pkg::t_out_item o_data
);

    // ---------------------------------------------------------------
    // Configuration registers; unchecked: the user sends writes only while the block idles
    // ---------------------------------------------------------------
    gehb_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (gehb_pkg::t_cfg_idx'(i_cfg_idx))
                gehb_pkg::CFG_SRC_IP_PAIR: r_cfg.src_ip_pair <= i_cfg_data;
                gehb_pkg::CFG_DST_IP_PAIR: r_cfg.dst_ip_pair <= i_cfg_data;
                gehb_pkg::CFG_PORT_QUAD:   r_cfg.port_quad   <= i_cfg_data;
                gehb_pkg::CFG_SRC_MAC_FWD: r_cfg.src_mac_fwd <= i_cfg_data[47:0];
                gehb_pkg::CFG_SRC_MAC_REV: r_cfg.src_mac_rev <= i_cfg_data[47:0];
                gehb_pkg::CFG_DST_MAC_FWD: r_cfg.dst_mac_fwd <= i_cfg_data[47:0];
                gehb_pkg::CFG_DST_MAC_REV: r_cfg.dst_mac_rev <= i_cfg_data[47:0];
                gehb_pkg::CFG_TENANT_CTL:  r_cfg.tenant_ctl  <= i_cfg_data[25:0];
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Header pipeline: select fields, sum, fold checksum, assemble
    // ---------------------------------------------------------------
    logic               pipe_vld;
    logic               ser_ready;
    gehb_pkg::t_hdr_set pipe_hdr;

    gehb_hdr_pipe u_pipe (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (pipe_vld),
        .i_take  (ser_ready),
        .o_hdr   (pipe_hdr)
    );

    // ---------------------------------------------------------------
    // Output serializer: hold one header, shift out a word per accept.
    // The current word always sits at the bottom of the shift register.
    // ---------------------------------------------------------------
    logic                                r_busy;
    logic                                r_drop;
    logic [2:0]                          r_idx;
    logic [gehb_pkg::NUM_WORDS-1:0][63:0] r_hdr;

    logic                                n_busy;
    logic                                n_drop;
    logic [2:0]                          n_idx;
    logic [gehb_pkg::NUM_WORDS-1:0][63:0] n_hdr;

    logic out_last;
    logic out_take;
    logic load;

    // A drop item is a single result; otherwise the last word ends the item
    assign out_last  = r_drop || (r_idx == gehb_pkg::LAST_WORD);
    assign out_take  = r_busy && !i_stall;
    // Take the next header when idle or while the final word of the current one leaves
    assign ser_ready = !r_busy || (out_take && out_last);
    assign load      = pipe_vld && ser_ready;

    always_comb begin
        n_busy = r_busy;
        n_drop = r_drop;
        n_idx  = r_idx;
        n_hdr  = r_hdr;
        if (load) begin
            n_busy = 1'b1;
            n_drop = pipe_hdr.drop;
            n_idx  = '0;
            n_hdr  = pipe_hdr.words;
        end else if (out_take) begin
            if (out_last) begin
                n_busy = 1'b0;
            end else begin
                n_idx = r_idx + 3'd1;
                n_hdr = {64'h0, r_hdr[gehb_pkg::NUM_WORDS-1:1]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= n_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_drop <= n_drop;
        r_idx  <= n_idx;
        r_hdr  <= n_hdr;
    end

    // Drive the result item; a dropped item shows zeros in the data fields
    assign o_valid = r_busy;

    always_comb begin
        o_data.hdr_word    = r_drop ? 64'h0 : r_hdr[0];
        o_data.word_index  = r_drop ? 3'd0 : r_idx;
        if (r_drop) begin
            o_data.valid_bytes = 4'd0;
        end else if (r_idx == gehb_pkg::LAST_WORD) begin
            o_data.valid_bytes = gehb_pkg::BYTES_LAST;
        end else begin
            o_data.valid_bytes = gehb_pkg::BYTES_FULL;
        end
        o_data.drop = r_drop;
        o_data.last = out_last;
    end

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_drop_single : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.drop |-> o_data.last && (o_data.word_index == 3'd0))
        else $error("drop item is not a single last result");

    a_word_advance : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && !o_data.last
        |=> o_valid && (o_data.word_index == $past(o_data.word_index) + 3'd1))
        else $error("header words not delivered in order");

    a_tail_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.last && !o_data.drop |-> o_data.hdr_word[15:0] == 16'h0)
        else $error("padding of last header word is not zero");

    a_no_overwrite : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(r_idx))
        else $error("stalled header replaced before its words left");

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the GENEVE-over-UDP/IPv4 outer header builder.
`timescale 1ns / 100ps

module tb_top;

    // Header layout constants used by the predictor
    localparam logic [7:0]  HDR_VER_IHL   = 8'h45;
    localparam logic [7:0]  HDR_TTL       = 8'hFF;
    localparam logic [7:0]  HDR_PROTO_UDP = 8'd17;
    localparam logic [15:0] HDR_IP_EXTRA  = 16'd62;
    localparam logic [15:0] HDR_UDP_EXTRA = 16'd42;
    localparam logic [31:0] HDR_GNV_BASE  = 32'h0300_6558;
    localparam logic [31:0] HDR_GNV_OPT   = 32'hDEAD_BE02;
    localparam logic [15:0] HDR_ETH_IPV4  = 16'h0800;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int REPORT_LIMIT  = 10;
    localparam int ENABLE_BIT    = 24;
    localparam int STATIC_BIT    = 25;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_cfg_we = 1'b0;
    logic [2:0]          i_cfg_idx = '0;
    logic [63:0]         i_cfg_data = '0;
    logic                i_valid = 1'b0;
    logic                o_stall;
    gehb_pkg::t_in_item  i_data = '0;
    logic                o_valid;
    logic                i_stall = 1'b0;
    gehb_pkg::t_out_item o_data;

    geneve_encap_header_builder u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_data     (i_data),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_data     (o_data)
    );

    // Shadow copy of the register file, updated as each write goes out
    gehb_pkg::t_cfg      shadow_cfg = '0;
    // Header words still owed by the block, oldest first
    gehb_pkg::t_out_item words_due[$];

    int src_gap_pct   = 0;
    int snk_stall_pct = 0;
    int err_count     = 0;
    int cycle_count   = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Guard against a hung handshake
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // Receiver back-pressure: stall at random, at the rate of the current phase
    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(99) < snk_stall_pct);
    end

    // Check every accepted result against the oldest expected word
    always @(posedge i_clk) begin
        gehb_pkg::t_out_item want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (words_due.size() == 0) begin
                err_count++;
                if (err_count <= REPORT_LIMIT)
                    $display("ERROR: unexpected result %h", o_data);
            end else begin
                want = words_due.pop_front();
                if (o_data.hdr_word !== want.hdr_word || o_data.word_index !== want.word_index
                    || o_data.valid_bytes !== want.valid_bytes || o_data.drop !== want.drop
                    || o_data.last !== want.last) begin
                    err_count++;
                    if (err_count <= REPORT_LIMIT) begin
                        $display("ERROR: exp %h idx %0d vb %0d drop %b last %b",
                                 want.hdr_word, want.word_index, want.valid_bytes,
                                 want.drop, want.last);
                        $display("       got %h idx %0d vb %0d drop %b last %b",
                                 o_data.hdr_word, o_data.word_index, o_data.valid_bytes,
                                 o_data.drop, o_data.last);
                    end
                end
            end
        end
    end

    // Build the expected outer header for one accepted item and queue its words
    function automatic void predict_header(gehb_pkg::t_in_item it);
        logic [31:0] sip, dip, sum;
        logic [15:0] sport, dport, ip_len, udp_len, csum, etype;
        logic [47:0] edst, esrc;
        logic [63:0] w [8];
        gehb_pkg::t_out_item o;
        if (!shadow_cfg.tenant_ctl[ENABLE_BIT]) begin
            o = '0;
            o.drop = 1'b1;
            o.last = 1'b1;
            words_due.push_back(o);
            return;
        end
        sip     = it.direction ? shadow_cfg.src_ip_pair[31:0] : shadow_cfg.src_ip_pair[63:32];
        dip     = it.direction ? shadow_cfg.dst_ip_pair[31:0] : shadow_cfg.dst_ip_pair[63:32];
        sport   = it.direction ? shadow_cfg.port_quad[47:32] : shadow_cfg.port_quad[63:48];
        dport   = it.direction ? shadow_cfg.port_quad[15:0] : shadow_cfg.port_quad[31:16];
        ip_len  = it.payload_len + HDR_IP_EXTRA;
        udp_len = it.payload_len + HDR_UDP_EXTRA;
        // One's-complement sum of the IPv4 header with the checksum field at zero
        sum = {HDR_VER_IHL, 8'h00} + ip_len + {HDR_TTL, HDR_PROTO_UDP}
              + sip[31:16] + sip[15:0] + dip[31:16] + dip[15:0];
        sum = sum[15:0] + sum[31:16];
        sum = sum[15:0] + sum[31:16];
        csum = ~sum[15:0];
        if (shadow_cfg.tenant_ctl[STATIC_BIT]) begin
            edst  = it.direction ? shadow_cfg.dst_mac_rev : shadow_cfg.dst_mac_fwd;
            esrc  = it.direction ? shadow_cfg.src_mac_rev : shadow_cfg.src_mac_fwd;
            etype = HDR_ETH_IPV4;
        end else begin
            edst  = it.orig_dst_mac;
            esrc  = it.orig_src_mac;
            etype = it.orig_ethertype;
        end
        w[0] = {HDR_VER_IHL, 8'h00, ip_len, 32'h0};
        w[1] = {HDR_TTL, HDR_PROTO_UDP, csum, sip};
        w[2] = {dip, sport, dport};
        w[3] = {udp_len, 16'h0, HDR_GNV_BASE};
        w[4] = {shadow_cfg.tenant_ctl[23:0], 8'h00, HDR_GNV_OPT};
        w[5] = {it.flow_sid[63:1], it.flow_sid[0] | it.direction};
        w[6] = {edst, esrc[47:32]};
        w[7] = {esrc[31:0], etype, 16'h0};
        for (int k = 0; k < 8; k++) begin
            o.hdr_word    = w[k];
            o.word_index  = 3'(k);
            o.valid_bytes = (k == 7) ? 4'd6 : 4'd8;
            o.drop        = 1'b0;
            o.last        = (k == 7);
            words_due.push_back(o);
        end
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Write one register; the caller lowers the write enable after a group
    task automatic cfg_write(gehb_pkg::t_cfg_idx idx, logic [63:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        case (idx)
            gehb_pkg::CFG_SRC_IP_PAIR: shadow_cfg.src_ip_pair = data;
            gehb_pkg::CFG_DST_IP_PAIR: shadow_cfg.dst_ip_pair = data;
            gehb_pkg::CFG_PORT_QUAD:   shadow_cfg.port_quad   = data;
            gehb_pkg::CFG_SRC_MAC_FWD: shadow_cfg.src_mac_fwd = data[47:0];
            gehb_pkg::CFG_SRC_MAC_REV: shadow_cfg.src_mac_rev = data[47:0];
            gehb_pkg::CFG_DST_MAC_FWD: shadow_cfg.dst_mac_fwd = data[47:0];
            gehb_pkg::CFG_DST_MAC_REV: shadow_cfg.dst_mac_rev = data[47:0];
            default:                   shadow_cfg.tenant_ctl  = data[25:0];
        endcase
        @(negedge i_clk);
    endtask

    // Load the whole register file; call only while the block is idle
    task automatic load_config(logic [63:0] sip, logic [63:0] dip, logic [63:0] ports,
                               logic [63:0] smf, logic [63:0] smr, logic [63:0] dmf,
                               logic [63:0] dmr, logic [63:0] tctl);
        cfg_write(gehb_pkg::CFG_SRC_IP_PAIR, sip);
        cfg_write(gehb_pkg::CFG_DST_IP_PAIR, dip);
        cfg_write(gehb_pkg::CFG_PORT_QUAD, ports);
        cfg_write(gehb_pkg::CFG_SRC_MAC_FWD, smf);
        cfg_write(gehb_pkg::CFG_SRC_MAC_REV, smr);
        cfg_write(gehb_pkg::CFG_DST_MAC_FWD, dmf);
        cfg_write(gehb_pkg::CFG_DST_MAC_REV, dmr);
        cfg_write(gehb_pkg::CFG_TENANT_CTL, tctl);
        i_cfg_we <= 1'b0;
    endtask

    // Random register file; output mostly enabled, MAC mode either way
    task automatic load_random_config();
        logic [63:0] tctl;
        tctl = rand64();
        tctl[ENABLE_BIT] = ($urandom_range(99) < 85);
        load_config(rand64(), rand64(), rand64(), rand64(), rand64(), rand64(), rand64(), tctl);
    endtask

    // Offer one item after a random gap, hold it until accepted, then predict it.
    // Enter and leave at a falling edge; valid stays high for the next item.
    task automatic send_item(gehb_pkg::t_in_item it);
        int gap;
        gap = 0;
        while (gap < 30 && $urandom_range(99) < src_gap_pct)
            gap++;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= it;
        do @(posedge i_clk); while (o_stall);
        predict_header(it);
        @(negedge i_clk);
    endtask

    // Hold off new items until every owed word has come out
    task automatic drain();
        if (i_valid)
            i_valid <= 1'b0;
        while (words_due.size() != 0)
            @(negedge i_clk);
    endtask

    function automatic gehb_pkg::t_in_item make_item(
        logic dir, logic [63:0] sid, logic [15:0] plen,
        logic [47:0] dmac, logic [47:0] smac, logic [15:0] etype);
        gehb_pkg::t_in_item it;
        it.direction      = dir;
        it.flow_sid       = sid;
        it.payload_len    = plen;
        it.orig_dst_mac   = dmac;
        it.orig_src_mac   = smac;
        it.orig_ethertype = etype;
        return it;
    endfunction

    function automatic gehb_pkg::t_in_item random_item();
        logic [15:0] plen;
        int pick;
        pick = $urandom_range(99);
        if (pick < 15)
            plen = 16'($urandom_range(1500));
        else if (pick < 30)
            plen = 16'($urandom_range(65535, 65460));
        else
            plen = 16'($urandom);
        return make_item(1'($urandom), rand64(), plen, 48'(rand64()), 48'(rand64()),
                         16'($urandom));
    endfunction

    // Registers come out of reset at zero, so output is disabled: expect drops
    task automatic test_reset_state();
        send_item(make_item(1'b0, '1, 16'hFFFF, '1, '1, '1));
        send_item(make_item(1'b1, '0, 16'h0000, '0, '0, '0));
        drain();
    endtask

    // Copy mode: length wrap points, both directions, field extremes
    task automatic test_field_extremes();
        load_config(64'hC0A8_0001_0A00_0001, 64'hC0A8_0002_0A00_0002,
                    64'h1234_5678_17C1_17C1, '0, '0, '0, '0,
                    (64'h1 << ENABLE_BIT) | 64'h00AB_CDEF);
        send_item(make_item(1'b0, '0, 16'd0, '0, '0, '0));
        send_item(make_item(1'b1, '1, 16'hFFFF, '1, '1, '1));
        send_item(make_item(1'b0, 64'h0123_4567_89AB_CDEF, 16'd65473,
                            48'hA5A5_A5A5_A5A5, 48'h5A5A_5A5A_5A5A, 16'h86DD));
        send_item(make_item(1'b1, 64'hFFFF_FFFF_FFFF_FFFE, 16'd65474,
                            48'h0000_0000_0001, 48'h8000_0000_0000, 16'h8100));
        send_item(make_item(1'b0, 64'hFFFF_FFFF_0000_0000, 16'd65494,
                            48'hFFFF_0000_FFFF, 48'h0000_FFFF_0000, 16'h0800));
        send_item(make_item(1'b1, 64'h0, 16'd65493, '1, '0, 16'h0001));
        send_item(make_item(1'b0, 64'h1, 16'd1500, 48'h0102_0304_0506, 48'h0A0B_0C0D_0E0F,
                            16'hFFFF));
        drain();
    endtask

    // Static MAC mode for both directions; upper write bits must be masked off
    task automatic test_static_mac();
        load_config(64'h0A01_0101_0A02_0202, 64'h0A03_0303_0A04_0404,
                    64'h4000_4001_17C1_17C2,
                    64'hFFFF_0011_2233_4455, 64'hFFFF_6677_8899_AABB,
                    64'hFFFF_CCDD_EEFF_0011, 64'hFFFF_2233_4455_6677,
                    64'hFFFF_FFFF_FC00_0000 | (64'h3 << ENABLE_BIT) | 64'h0012_3456);
        send_item(make_item(1'b0, 64'hDEAD_BEEF_CAFE_F00D, 16'd64, '1, '1, '1));
        send_item(make_item(1'b1, 64'hDEAD_BEEF_CAFE_F00C, 16'd9000, '0, '0, '0));
        send_item(make_item(1'b1, '1, 16'hFFFF, 48'h1234_5678_9ABC, '0, 16'h1234));
        drain();
    endtask

    // Register extremes: all ones, all zero except enable, disabled with static set
    task automatic test_config_extremes();
        load_config('1, '1, '1, '1, '1, '1, '1, '1);
        send_item(make_item(1'b0, '0, 16'hFFFF, '0, '0, '0));
        send_item(make_item(1'b1, '1, 16'd0, '1, '1, '1));
        drain();
        load_config('0, '0, '0, '0, '0, '0, '0, 64'h1 << ENABLE_BIT);
        send_item(make_item(1'b0, '1, 16'd0, '1, '1, '1));
        send_item(make_item(1'b1, '0, 16'hFFFF, '0, '0, '0));
        drain();
        load_config('1, '1, '1, '1, '1, '1, '1, 64'h1 << STATIC_BIT);
        send_item(make_item(1'b0, '1, 16'd100, '1, '1, '1));
        send_item(make_item(1'b1, '0, 16'd100, '0, '0, '0));
        drain();
    endtask

    // Random items under one idling pattern, reconfiguring every few dozen items
    task automatic test_random_traffic(int gap_pct, int stall_pct, int n_items);
        src_gap_pct   = gap_pct;
        snk_stall_pct = stall_pct;
        for (int n = 0; n < n_items; n++) begin
            if (n % 35 == 0) begin
                drain();
                load_random_config();
            end
            send_item(random_item());
        end
        drain();
    endtask

    initial begin
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_reset_state();
        test_field_extremes();
        test_static_mac();
        test_config_extremes();
        test_random_traffic(28, 75, 100);
        test_random_traffic(75, 28, 100);
        test_random_traffic(0, 0, 100);

        // Let any stray words surface before deciding
        repeat (16) @(negedge i_clk);
        if (err_count == 0 && words_due.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
